// File: hw/rtl/ajrb_pkg.sv
`timescale 1ns / 1ps

package ajrb_pkg;

	localparam int unsigned SLOTS_DEF  = 16;
	localparam int unsigned SEQ_W      = 16;
	localparam int unsigned REF_W      = 32;
	localparam int unsigned FILL_W     = 5;
	localparam int unsigned PREFILL_W  = 5;
	localparam int unsigned GAP_W      = 16;
	localparam int unsigned APB_DW     = 32;
	localparam int unsigned APB_AW     = 3;

	localparam logic [PREFILL_W-1:0] PREFILL_RST = 5'd3;
	localparam logic [GAP_W-1:0]     MAX_GAP_RST = 16'd50;

	// item kinds
	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	typedef enum logic {
		REG_PREFILL,
		REG_MAX_GAP
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [PREFILL_W-1:0] prefill_frames;
		logic [GAP_W-1:0]     max_gap;
	} cfg_t;

	typedef struct packed {
		logic [SEQ_W-1:0] seq_num;
		logic [REF_W-1:0] frame_ref;
	} slot_t;

endpackage

// File: hw/rtl/ajrb_slot_mem.sv
`timescale 1ns / 1ps

// Slot table: one write port, one read port, registered read data.
module ajrb_slot_mem #(
	parameter int unsigned DEPTH = ajrb_pkg::SLOTS_DEF,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  ajrb_pkg::slot_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output ajrb_pkg::slot_t rdata
);
	import ajrb_pkg::*;

	slot_t mem_q [DEPTH];
	slot_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/ajrb_cfg_regs.sv
`timescale 1ns / 1ps

// APB register file: prefill threshold and gap limit.
module ajrb_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ajrb_pkg::APB_AW-1:0] paddr,
	input  logic [ajrb_pkg::APB_DW-1:0] pwdata,
	output logic [ajrb_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	output ajrb_pkg::cfg_t              cfg
);
	import ajrb_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[APB_AW-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prefill_frames <= PREFILL_RST;
			cfg_q.max_gap        <= MAX_GAP_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PREFILL: cfg_q.prefill_frames <= pwdata[PREFILL_W-1:0];
				REG_MAX_GAP: cfg_q.max_gap        <= pwdata[GAP_W-1:0];
				default:     cfg_q                <= cfg_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_PREFILL: prdata = APB_DW'(cfg_q.prefill_frames);
			REG_MAX_GAP: prdata = APB_DW'(cfg_q.max_gap);
			default:     prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/audio_jitter_reorder_buffer.sv
`timescale 1ns / 1ps

// Audio jitter reorder buffer. Each item is a frame arrival (req_type 0) or a
// playout tick (req_type 1) and yields exactly one result, shown for one cycle
// with done high; the receiver cannot stall, so sample the result on that cycle.
// An item is taken when start is high and busy is low. A tick that finds the
// table empty, the buffer unprimed or fewer frames than prefill_frames stored
// finishes at once: done rises the cycle after it is taken. Every other item
// walks the slot table through the single read port of the slot memory, one
// entry per cycle, then passes the DRAIN and FINISH states before done, and
// busy drops in the cycle done is shown, so the next item may be taken then.
// Slot contents live in a synchronous memory; valid bits, fill count, expected
// sequence number and the primed flag are flip-flops, so reset is immediate and
// there is no clearing pass. Registers: prefill_frames at 0x0, max_gap at 0x4.
module audio_jitter_reorder_buffer #(
	parameter int unsigned SLOTS = ajrb_pkg::SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          start,
	output logic                          busy,
	input  logic                          req_type,
	input  logic [ajrb_pkg::SEQ_W-1:0]    seq_num,
	input  logic [ajrb_pkg::REF_W-1:0]    frame_ref,
	// result channel
	output logic                          done,
	output logic                          played,
	output logic [ajrb_pkg::SEQ_W-1:0]    played_seq,
	output logic [ajrb_pkg::REF_W-1:0]    played_ref,
	output logic                          flushed,
	output logic                          dropped,
	output logic [ajrb_pkg::FILL_W-1:0]   fill_count,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ajrb_pkg::APB_AW-1:0]   paddr,
	input  logic [ajrb_pkg::APB_DW-1:0]   pwdata,
	output logic [ajrb_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import ajrb_pkg::*;

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned CW = $clog2(SLOTS + 1);
	localparam int unsigned PW = (CW > PREFILL_W) ? CW : PREFILL_W;

	state_t state_q, state_d;
	cfg_t   cfg;

	// buffer state
	logic [SLOTS-1:0] valid_q;
	logic [SEQ_W-1:0] next_q;
	logic             primed_q;
	logic [CW-1:0]    count_q;

	// item being worked on
	logic             tick_q;
	logic [SEQ_W-1:0] key_q;
	logic [REF_W-1:0] ref_q;

	// table walk
	logic [IW-1:0]    addr_q;
	logic             rd_vld_s1;
	logic [IW-1:0]    rd_idx_s1;
	slot_t            rd_data;
	logic             hit_q;
	logic [IW-1:0]    hit_idx_q;
	logic [REF_W-1:0] hit_ref_q;
	logic             free_q;
	logic [IW-1:0]    free_idx_q;
	logic             low_q;
	logic [IW-1:0]    low_idx_q;
	logic [SEQ_W-1:0] low_seq_q;
	logic [REF_W-1:0] low_ref_q;

	// result registers
	logic              done_q;
	logic              played_q;
	logic [SEQ_W-1:0]  played_seq_q;
	logic [REF_W-1:0]  played_ref_q;
	logic              flushed_q;
	logic              dropped_q;
	logic [FILL_W-1:0] fill_q;

	// control
	logic             accept;
	logic             tick_in;
	logic             count_zero;
	logic             may_play;
	logic             walk;
	logic             last_addr;
	logic             ent_valid;
	logic             rd_en;
	logic             fin;
	logic             we;
	logic [IW-1:0]    waddr;
	slot_t            wdata;
	logic [SEQ_W-1:0] gap;
	logic             do_flush;
	logic             do_play;
	logic             do_store;
	logic             do_drop;
	logic             do_prime;
	logic [IW-1:0]    play_idx;
	logic [SEQ_W-1:0] play_seq;
	logic [REF_W-1:0] play_ref;
	logic [CW-1:0]    count_fin;

	ajrb_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The walk reads and the final write-back never overlap in time: the FSM
	// handles one item at a time and writes only in FINISH.
	ajrb_slot_mem #(
		.DEPTH (SLOTS),
		.AW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign tick_in    = (req_type == REQ_TICK);
	assign count_zero = (count_q == '0);
	assign may_play   = primed_q && (PW'(count_q) >= PW'(cfg.prefill_frames));
	// arrivals always walk; ticks only when a frame may be released
	assign walk       = !tick_in || (!count_zero && may_play);
	assign last_addr  = (addr_q == IW'(SLOTS - 1));
	assign ent_valid  = valid_q[rd_idx_s1];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (accept && walk) state_d = ST_SCAN;
			ST_SCAN:   if (last_addr) state_d = ST_DRAIN;
			ST_DRAIN:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// FSM outputs and end-of-walk decision
	always_comb begin
		rd_en    = (state_q == ST_SCAN);
		fin      = (state_q == ST_FINISH);
		gap      = low_seq_q - next_q;
		do_flush = tick_q && !hit_q && low_q && (gap > cfg.max_gap);
		do_play  = tick_q && !do_flush && (hit_q || low_q);
		do_store = !tick_q && !hit_q && free_q;
		do_drop  = !tick_q && !hit_q && !free_q;
		do_prime = !tick_q && (hit_q || free_q) && !primed_q;
		play_idx = hit_q ? hit_idx_q : low_idx_q;
		play_seq = hit_q ? key_q : low_seq_q;
		play_ref = hit_q ? hit_ref_q : low_ref_q;
		we       = fin && !tick_q && (hit_q || free_q);
		waddr    = hit_q ? hit_idx_q : free_idx_q;
		wdata    = '{seq_num: key_q, frame_ref: ref_q};
		if (do_flush) begin
			count_fin = '0;
		end else if (do_play) begin
			count_fin = count_q - CW'(1);
		end else if (do_store) begin
			count_fin = count_q + CW'(1);
		end else begin
			count_fin = count_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			valid_q   <= '0;
			next_q    <= '0;
			primed_q  <= 1'b0;
			count_q   <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			// strobe after a short tick or at the end of a walk
			done_q    <= (accept && !walk) || fin;
			if (accept && !walk) begin
				// short tick: only an empty table changes state
				if (count_zero) begin
					primed_q <= 1'b0;
				end
			end
			if (fin) begin
				count_q <= count_fin;
				if (do_flush) begin
					valid_q  <= '0;
					next_q   <= '0;
					primed_q <= 1'b0;
				end else if (do_play) begin
					valid_q[play_idx] <= 1'b0;
					next_q            <= play_seq + SEQ_W'(1);
				end
				if (do_store) begin
					valid_q[free_idx_q] <= 1'b1;
				end
				if (do_prime) begin
					next_q   <= key_q;
					primed_q <= 1'b1;
				end
			end
		end
	end

	// item capture and walk bookkeeping
	always_ff @(posedge clk) begin
		if (accept) begin
			tick_q <= tick_in;
			key_q  <= tick_in ? next_q : seq_num;
			ref_q  <= frame_ref;
			addr_q <= '0;
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			low_q  <= 1'b0;
		end else begin
			if (rd_en) begin
				addr_q <= addr_q + IW'(1);
			end
			rd_idx_s1 <= addr_q;
			if (rd_vld_s1) begin
				if (ent_valid && (rd_data.seq_num == key_q) && !hit_q) begin
					hit_q     <= 1'b1;
					hit_idx_q <= rd_idx_s1;
					hit_ref_q <= rd_data.frame_ref;
				end
				if (!ent_valid && !free_q) begin
					free_q     <= 1'b1;
					free_idx_q <= rd_idx_s1;
				end
				// first entry with the strictly lowest number wins
				if (ent_valid && (!low_q || (rd_data.seq_num < low_seq_q))) begin
					low_q     <= 1'b1;
					low_idx_q <= rd_idx_s1;
					low_seq_q <= rd_data.seq_num;
					low_ref_q <= rd_data.frame_ref;
				end
			end
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (accept && !walk) begin
			played_q     <= 1'b0;
			played_seq_q <= '0;
			played_ref_q <= '0;
			flushed_q    <= 1'b0;
			dropped_q    <= 1'b0;
			fill_q       <= FILL_W'(count_q);
		end else if (fin) begin
			played_q     <= do_play;
			played_seq_q <= do_play ? play_seq : '0;
			played_ref_q <= do_play ? play_ref : '0;
			flushed_q    <= do_flush;
			dropped_q    <= do_drop;
			fill_q       <= FILL_W'(count_fin);
		end
	end

	assign done       = done_q;
	assign played     = played_q;
	assign played_seq = played_seq_q;
	assign played_ref = played_ref_q;
	assign flushed    = flushed_q;
	assign dropped    = dropped_q;
	assign fill_count = fill_q;

`ifndef ASSERT_OFF
	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("fill count differs from number of valid slots");

	a_stored_means_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> primed_q)
		else $error("frames stored while unprimed");

	a_accept_progresses: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (done || busy))
		else $error("accepted item neither finished nor in progress");

	a_finish_strobes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> (done && !busy))
		else $error("walk finished without a result strobe");

	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(fin && do_flush) |=> ((valid_q == '0) && !primed_q && (next_q == '0)))
		else $error("flush left buffer state behind");
`endif

endmodule

// File: sim/ajrb_checker.sv
`timescale 1ns / 1ps

// Watches the item, result and register ports; keeps its own copy of the
// slot table and compares every done strobe with the oldest prediction.
module ajrb_checker
	import ajrb_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               req_type,
	input  logic [SEQ_W-1:0]   seq_num,
	input  logic [REF_W-1:0]   frame_ref,
	input  logic               done,
	input  logic               played,
	input  logic [SEQ_W-1:0]   played_seq,
	input  logic [REF_W-1:0]   played_ref,
	input  logic               flushed,
	input  logic               dropped,
	input  logic [FILL_W-1:0]  fill_count,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [APB_AW-1:0]  paddr,
	input  logic [APB_DW-1:0]  pwdata,
	input  logic               pready,
	output int                 errors,
	output int                 outstanding
);

	typedef struct packed {
		logic              played;
		logic [SEQ_W-1:0]  seq;
		logic [REF_W-1:0]  payload;
		logic              flushed;
		logic              dropped;
		logic [FILL_W-1:0] fill;
	} outcome_t;

	logic              occupied [SLOTS];
	logic [SEQ_W-1:0]  occ_seq  [SLOTS];
	logic [REF_W-1:0]  occ_ref  [SLOTS];
	logic [SEQ_W-1:0]  want_seq;
	logic              is_primed;
	int                frames_held;
	logic [PREFILL_W-1:0] cfg_prefill;
	logic [GAP_W-1:0]  cfg_gap;
	outcome_t          outcome_q [$];
	outcome_t          want;
	int                result_idx;

	task automatic flag_error(input string msg);
		$display("%t ERROR %s", $realtime, msg);
		errors++;
	endtask

	function automatic void empty_table();
		for (int i = 0; i < SLOTS; i++)
			occupied[i] = 1'b0;
		want_seq = '0;
		is_primed = 1'b0;
		frames_held = 0;
	endfunction

	function automatic int slot_holding(input logic [SEQ_W-1:0] s);
		int found;
		found = -1;
		for (int i = 0; i < SLOTS; i++)
			if (found < 0 && occupied[i] && occ_seq[i] == s)
				found = i;
		return found;
	endfunction

	// advances the table by one item and returns the status it should report
	function automatic outcome_t buffer_outcome(input logic kind,
			input logic [SEQ_W-1:0] s, input logic [REF_W-1:0] r);
		outcome_t o;
		int hit;
		logic [SEQ_W-1:0] gap;
		o = '0;
		hit = -1;
		if (kind == REQ_ARRIVAL) begin
			hit = slot_holding(s);
			if (hit >= 0) begin
				occ_ref[hit] = r;
			end else begin
				for (int i = 0; i < SLOTS; i++)
					if (hit < 0 && !occupied[i])
						hit = i;
				if (hit >= 0) begin
					occupied[hit] = 1'b1;
					occ_seq[hit] = s;
					occ_ref[hit] = r;
					frames_held++;
				end else begin
					o.dropped = 1'b1;
				end
			end
			if (hit >= 0 && !is_primed) begin
				want_seq = s;
				is_primed = 1'b1;
			end
		end else if (frames_held == 0) begin
			is_primed = 1'b0;
		end else if (is_primed && frames_held >= int'(cfg_prefill)) begin
			hit = slot_holding(want_seq);
			if (hit < 0) begin
				for (int i = 0; i < SLOTS; i++)
					if (occupied[i] && (hit < 0 || occ_seq[i] < occ_seq[hit]))
						hit = i;
				gap = occ_seq[hit] - want_seq;
				if (gap > cfg_gap) begin
					empty_table();
					o.flushed = 1'b1;
					hit = -1;
				end
			end
			if (hit >= 0) begin
				o.played = 1'b1;
				o.seq = occ_seq[hit];
				o.payload = occ_ref[hit];
				occupied[hit] = 1'b0;
				frames_held--;
				want_seq = occ_seq[hit] + 1'b1;
			end
		end
		o.fill = frames_held[FILL_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_table();
			cfg_prefill = PREFILL_RST;
			cfg_gap = MAX_GAP_RST;
			outcome_q.delete();
			result_idx = 0;
			outstanding <= 0;
		end else begin
			// a result retires before an item taken on the same edge is predicted
			if (done) begin
				if (outcome_q.size() == 0) begin
					flag_error($sformatf("result %0d with nothing outstanding", result_idx));
				end else begin
					want = outcome_q.pop_front();
					if (played !== want.played)
						flag_error($sformatf("result %0d: played %0b, predicted %0b",
							result_idx, played, want.played));
					if (played_seq !== want.seq)
						flag_error($sformatf("result %0d: played_seq %0h, predicted %0h",
							result_idx, played_seq, want.seq));
					if (played_ref !== want.payload)
						flag_error($sformatf("result %0d: played_ref %0h, predicted %0h",
							result_idx, played_ref, want.payload));
					if (flushed !== want.flushed)
						flag_error($sformatf("result %0d: flushed %0b, predicted %0b",
							result_idx, flushed, want.flushed));
					if (dropped !== want.dropped)
						flag_error($sformatf("result %0d: dropped %0b, predicted %0b",
							result_idx, dropped, want.dropped));
					if (fill_count !== want.fill)
						flag_error($sformatf("result %0d: fill_count %0d, predicted %0d",
							result_idx, fill_count, want.fill));
				end
				result_idx++;
			end
			if (start && !busy)
				outcome_q.push_back(buffer_outcome(req_type, seq_num, frame_ref));
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[APB_AW-1:2]))
					REG_PREFILL: cfg_prefill = pwdata[PREFILL_W-1:0];
					REG_MAX_GAP: cfg_gap = pwdata[GAP_W-1:0];
					default: ;
				endcase
			end
			outstanding <= outcome_q.size();
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the jitter reorder buffer. The checker instance
// beside the block does all prediction and comparison; this module only
// drives items and register writes and reads back the error and outstanding counts.
module testbench;
	import ajrb_pkg::*;

	localparam int unsigned SLOTS = SLOTS_DEF;
	// longest item walks all SLOTS entries; DRAIN adds a little slack on top
	localparam int DRAIN     = SLOTS + 4;
	// ~680 items, each with its idle gap and slot walk; LIMIT allows far more
	localparam int LIMIT     = 400000;
	localparam int PHASES    = 8;
	localparam int PER_PHASE = 82;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              req_type = REQ_ARRIVAL;
	logic [SEQ_W-1:0]  seq_num = '0;
	logic [REF_W-1:0]  frame_ref = '0;
	logic              done;
	logic              played;
	logic [SEQ_W-1:0]  played_seq;
	logic [REF_W-1:0]  played_ref;
	logic              flushed;
	logic              dropped;
	logic [FILL_W-1:0] fill_count;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	int                errors;
	int                outstanding;
	int                cycles = 0;
	bit                no_gaps = 1'b0;
	// head of the simulated sender's stream; arrivals cluster around it
	logic [SEQ_W-1:0]  stream_seq = '0;

	always #5 clk = ~clk;

	audio_jitter_reorder_buffer #(.SLOTS(SLOTS)) dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .seq_num(seq_num), .frame_ref(frame_ref),
		.done(done), .played(played), .played_seq(played_seq),
		.played_ref(played_ref), .flushed(flushed), .dropped(dropped),
		.fill_count(fill_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	ajrb_checker #(.SLOTS(SLOTS)) chk (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy),
		.req_type(req_type), .seq_num(seq_num), .frame_ref(frame_ref),
		.done(done), .played(played), .played_seq(played_seq),
		.played_ref(played_ref), .flushed(flushed), .dropped(dropped),
		.fill_count(fill_count),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.errors(errors), .outstanding(outstanding)
	);

	// watchdog: any hang ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("audio_jitter_reorder_buffer: mismatch");
			$finish;
		end
	end

	// Called at a rising edge; returns at the edge that takes the item.
	// The idle gap counts from the previous acceptance, so it lands anywhere
	// in the block's slot walk. Gap 0 keeps start high straight through.
	task automatic send_item(input logic kind, input logic [SEQ_W-1:0] s,
			input logic [REF_W-1:0] r);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		req_type  <= kind;
		seq_num   <= s;
		frame_ref <= r;
		do @(posedge clk); while (busy);
	endtask

	// drop start and wait for every predicted result, then the slot walk time
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	// setup cycle, access cycle, then idle with psel low so back-to-back calls
	// never assign psel twice in one step
	task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] v);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly a plausible network stream: in-order frames with small reorder,
	// loss and repeats, plus ticks. The rest is late repeats, random numbers
	// and jumps of the stream base (often to just below the wrap point).
	task automatic random_item();
		int pick;
		logic [SEQ_W-1:0] s;
		pick = $urandom_range(0, 99);
		if (pick < 48) begin
			// tick; the payload fields carry junk that must be ignored
			send_item(REQ_TICK, SEQ_W'($urandom), $urandom);
		end else begin
			if (pick < 82) begin
				s = stream_seq + SEQ_W'($urandom_range(0, 3));
				if ($urandom_range(0, 3) != 0)
					stream_seq = stream_seq + 1'b1;
			end else if (pick < 90) begin
				s = stream_seq - SEQ_W'($urandom_range(1, 4));
			end else if (pick < 95) begin
				s = SEQ_W'($urandom);
			end else begin
				stream_seq = $urandom_range(0, 1) ? SEQ_W'($urandom_range(65528, 65535))
					: SEQ_W'($urandom);
				s = stream_seq;
			end
			send_item(REQ_ARRIVAL, s, $urandom);
		end
	endtask

	initial begin
		logic [APB_DW-1:0] pf;
		logic [APB_DW-1:0] mg;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Directed, reset settings (prefill 3, gap 50).
		send_item(REQ_TICK, 16'h0000, 32'h0000_0000);          // empty and unprimed
		send_item(REQ_ARRIVAL, 16'hFFFF, 32'hFFFF_FFFF);       // primes, expects 0xFFFF
		send_item(REQ_ARRIVAL, 16'h0000, 32'h0000_0000);
		send_item(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);          // two held, below prefill
		send_item(REQ_ARRIVAL, 16'h0000, 32'h1234_5678);       // repeat: payload replaced
		for (int k = 0; k < 14; k++)                           // fills all 16 slots
			send_item(REQ_ARRIVAL, SEQ_W'(100 + k), $urandom);
		send_item(REQ_ARRIVAL, 16'h0007, 32'hDEAD_BEEF);       // new number, table full
		send_item(REQ_ARRIVAL, 16'h0069, 32'hA5A5_5A5A);       // repeat while full is kept
		send_item(REQ_TICK, 16'h0000, 32'h0000_0000);          // plays 0xFFFF
		send_item(REQ_TICK, 16'h0000, 32'h0000_0000);          // wraps, plays 0
		send_item(REQ_TICK, 16'h0000, 32'h0000_0000);          // 1 missing, 100 too far: flush
		send_item(REQ_TICK, 16'h0000, 32'h0000_0000);          // empty again
		settle();

		// Random phases, each under its own register settings, extremes first.
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin pf = 0;  mg = 32'hFFFF_FFFF; end
				1: begin pf = 1;  mg = 0; end
				2: begin pf = 16; mg = $urandom_range(0, 300); end
				3: begin pf = 20; mg = 50; end        // prefill above table: never plays
				4: begin pf = 3;  mg = 1; end
				5: begin pf = 2;  mg = $urandom; end
				6: begin pf = 31; mg = 65535; end
				default: begin pf = $urandom_range(0, 16); mg = $urandom_range(0, 1000); end
			endcase
			write_reg(REG_PREFILL, pf);
			write_reg(REG_MAX_GAP, mg);
			if ($urandom_range(0, 1))
				stream_seq = SEQ_W'($urandom_range(65500, 65535));
			for (int n = 0; n < PER_PHASE; n++) begin
				// stretches of back-to-back items now and then
				if (n % 40 == 0)
					no_gaps = ($urandom_range(0, 2) == 0);
				random_item();
			end
			settle();
		end

		if (errors == 0 && outstanding == 0)
			$display("audio_jitter_reorder_buffer: match");
		else
			$display("audio_jitter_reorder_buffer: mismatch");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/ajrb_pkg.sv
hw/rtl/ajrb_slot_mem.sv
hw/rtl/ajrb_cfg_regs.sv
hw/rtl/audio_jitter_reorder_buffer.sv
sim/ajrb_checker.sv
sim/testbench.sv
